// File: hdl/i2cbs_pkg.sv
// i2cbs_pkg: types, operation and phase codes, and the phase programs of the
// i2c master bit sequencer. No dependencies; imported by every module of the block.

package i2cbs_pkg;

	localparam int PhaseW = 16;
	localparam int StepW = 5;
	localparam int StepChain = 4;

	// operation codes, OP_IDLE doubles as the no-operation state
	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ = 3'd3,
		OP_SEND_ACK = 3'd4,
		OP_RECV_ACK = 3'd5,
		OP_PROBE = 3'd6,
		OP_IDLE = 3'd7
	} op_t;

	// program entry kinds
	typedef enum logic [3:0] {
		K_END = 4'd0,
		K_OUT = 4'd1,
		K_IN = 4'd2,
		K_SDA = 4'd3,
		K_SDA_BIT = 4'd4,
		K_SCL = 4'd5,
		K_RD_ACK = 4'd6,
		K_RD_BIT = 4'd7,
		K_LOOP = 4'd8
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [StepW-1:0] arg;
	} entry_t;

	// one tick item
	typedef struct packed {
		logic cmd_valid;
		logic [2:0] operation;
		logic [7:0] tx_byte;
		logic ack_to_send;
		logic sda_level;
	} tick_t;

	// one result item
	typedef struct packed {
		logic scl_level;
		logic sda_drive;
		logic sda_output_enable;
		logic busy_res;
		logic done_res;
		logic [7:0] rx_byte;
		logic ack_seen;
	} res_t;

	// sequencer state
	typedef struct packed {
		op_t op;
		logic [StepW-1:0] phase_step;
		logic [2:0] bit_index;
		logic [PhaseW-1:0] tick_counter;
		logic [7:0] shift_data;
		logic [7:0] rx_last;
		logic ack;
		logic scl;
		logic sda;
		logic oe;
	} seq_t;

	localparam logic [2:0] BitLast = 3'd7;

	function automatic entry_t mk(input kind_t kind, input logic [StepW-1:0] arg);
		entry_t e;
		e.kind = kind;
		e.arg = arg;
		return e;
	endfunction

	// phase program lookup; steps past the end read as end of program
	function automatic entry_t prog_entry(input op_t op, input logic [StepW-1:0] step);
		entry_t e;
		e = mk(K_END, 5'd0);
		case (op)
			OP_START: begin
				case (step)
					5'd0: e = mk(K_OUT, 5'd0);
					5'd1: e = mk(K_SDA, 5'd1);
					5'd2: e = mk(K_SCL, 5'd1);
					5'd3: e = mk(K_SDA, 5'd0);
					5'd4: e = mk(K_SCL, 5'd0);
					default: e = mk(K_END, 5'd0);
				endcase
			end
			OP_STOP: begin
				case (step)
					5'd0: e = mk(K_OUT, 5'd0);
					5'd1: e = mk(K_SDA, 5'd0);
					5'd2: e = mk(K_SCL, 5'd1);
					5'd3: e = mk(K_SDA, 5'd1);
					default: e = mk(K_END, 5'd0);
				endcase
			end
			OP_WRITE: begin
				case (step)
					5'd0: e = mk(K_OUT, 5'd0);
					5'd1: e = mk(K_SDA_BIT, 5'd0);
					5'd2: e = mk(K_SCL, 5'd1);
					5'd3: e = mk(K_SCL, 5'd0);
					5'd4: e = mk(K_LOOP, 5'd1);
					5'd5: e = mk(K_IN, 5'd0);
					5'd6: e = mk(K_SCL, 5'd1);
					5'd7: e = mk(K_RD_ACK, 5'd0);
					5'd8: e = mk(K_SCL, 5'd0);
					5'd9: e = mk(K_OUT, 5'd0);
					default: e = mk(K_END, 5'd0);
				endcase
			end
			OP_READ: begin
				case (step)
					5'd0: e = mk(K_OUT, 5'd0);
					5'd1: e = mk(K_SDA, 5'd1);
					5'd2: e = mk(K_IN, 5'd0);
					5'd3: e = mk(K_SCL, 5'd1);
					5'd4: e = mk(K_RD_BIT, 5'd0);
					5'd5: e = mk(K_SCL, 5'd0);
					5'd6: e = mk(K_LOOP, 5'd2);
					default: e = mk(K_END, 5'd0);
				endcase
			end
			OP_SEND_ACK: begin
				case (step)
					5'd0: e = mk(K_OUT, 5'd0);
					5'd1: e = mk(K_SDA_BIT, 5'd0);
					5'd2: e = mk(K_SCL, 5'd1);
					5'd3: e = mk(K_SCL, 5'd0);
					default: e = mk(K_END, 5'd0);
				endcase
			end
			OP_RECV_ACK: begin
				case (step)
					5'd0: e = mk(K_OUT, 5'd0);
					5'd1: e = mk(K_SDA, 5'd1);
					5'd2: e = mk(K_SCL, 5'd1);
					5'd3: e = mk(K_IN, 5'd0);
					5'd4: e = mk(K_RD_ACK, 5'd0);
					5'd5: e = mk(K_SCL, 5'd0);
					5'd6: e = mk(K_OUT, 5'd0);
					default: e = mk(K_END, 5'd0);
				endcase
			end
			OP_PROBE: begin
				case (step)
					5'd0: e = mk(K_OUT, 5'd0);
					5'd1: e = mk(K_SDA, 5'd1);
					5'd2: e = mk(K_SCL, 5'd1);
					5'd3: e = mk(K_SDA, 5'd0);
					5'd4: e = mk(K_SCL, 5'd0);
					5'd5: e = mk(K_OUT, 5'd0);
					5'd6: e = mk(K_SDA_BIT, 5'd0);
					5'd7: e = mk(K_SCL, 5'd1);
					5'd8: e = mk(K_SCL, 5'd0);
					5'd9: e = mk(K_LOOP, 5'd6);
					5'd10: e = mk(K_IN, 5'd0);
					5'd11: e = mk(K_SCL, 5'd1);
					5'd12: e = mk(K_RD_ACK, 5'd0);
					5'd13: e = mk(K_SCL, 5'd0);
					5'd14: e = mk(K_OUT, 5'd0);
					5'd15: e = mk(K_OUT, 5'd0);
					5'd16: e = mk(K_SDA, 5'd0);
					5'd17: e = mk(K_SCL, 5'd1);
					5'd18: e = mk(K_SDA, 5'd1);
					default: e = mk(K_END, 5'd0);
				endcase
			end
			default: e = mk(K_END, 5'd0);
		endcase
		return e;
	endfunction

endpackage

// File: hdl/i2cbs_step.sv
// i2cbs_step: one-tick next-state and result logic of the i2c master bit sequencer.
// Depends on i2cbs_pkg.

module i2cbs_step import i2cbs_pkg::*; (
	input seq_t cur,
	input tick_t tick,
	input logic [PhaseW-1:0] phase_ticks,
	output seq_t nxt,
	output res_t res
);

	logic done;

	// next state: command launch, phase hold count, then walk to the next timed phase
	always_comb begin
		logic [PhaseW-1:0] limit;
		logic run;
		logic going;
		logic ended;
		entry_t e;
		limit = (phase_ticks == '0) ? PhaseW'(1) : phase_ticks;
		nxt = cur;
		run = 1'b0;
		going = 1'b0;
		ended = 1'b0;
		e = mk(K_END, 5'd0);
		done = 1'b0;
		if (cur.op == OP_IDLE) begin
			if (tick.cmd_valid && (tick.operation != OP_IDLE)) begin
				nxt.op = op_t'(tick.operation);
				nxt.phase_step = '0;
				nxt.bit_index = '0;
				case (op_t'(tick.operation))
					OP_WRITE, OP_PROBE: nxt.shift_data = tick.tx_byte;
					OP_SEND_ACK: nxt.shift_data = {tick.ack_to_send, 7'd0};
					default: nxt.shift_data = 8'd0;
				endcase
				run = 1'b1;
			end
		end else if (cur.tick_counter < limit) begin
			nxt.tick_counter = cur.tick_counter + PhaseW'(1);
		end else begin
			run = 1'b1;
		end
		going = run;
		for (int i = 0; i < StepChain; i++) begin
			if (going) begin
				e = prog_entry(nxt.op, nxt.phase_step);
				nxt.phase_step = nxt.phase_step + StepW'(1);
				case (e.kind)
					K_OUT: nxt.oe = 1'b1;
					K_IN: begin
						nxt.sda = 1'b1;
						nxt.oe = 1'b0;
					end
					K_LOOP: begin
						if (nxt.bit_index < BitLast) begin
							nxt.bit_index = nxt.bit_index + 3'd1;
							nxt.phase_step = e.arg;
						end else begin
							nxt.bit_index = '0;
						end
					end
					K_SDA: begin
						nxt.sda = e.arg[0];
						nxt.tick_counter = PhaseW'(1);
						going = 1'b0;
					end
					K_SDA_BIT: begin
						nxt.sda = nxt.shift_data[BitLast - nxt.bit_index];
						nxt.tick_counter = PhaseW'(1);
						going = 1'b0;
					end
					K_SCL: begin
						nxt.scl = e.arg[0];
						nxt.tick_counter = PhaseW'(1);
						going = 1'b0;
					end
					K_RD_ACK: begin
						nxt.ack = tick.sda_level;
						nxt.tick_counter = PhaseW'(1);
						going = 1'b0;
					end
					K_RD_BIT: begin
						if (tick.sda_level) begin
							nxt.shift_data[BitLast - nxt.bit_index] = 1'b1;
						end
						nxt.tick_counter = PhaseW'(1);
						going = 1'b0;
					end
					default: begin
						ended = 1'b1;
						going = 1'b0;
					end
				endcase
			end
		end
		// end of program: latch a read byte and return to idle
		if (ended || going) begin
			if (nxt.op == OP_READ) begin
				nxt.rx_last = nxt.shift_data;
			end
			nxt.op = OP_IDLE;
			nxt.phase_step = '0;
			nxt.bit_index = '0;
			nxt.tick_counter = '0;
			done = 1'b1;
		end
	end

	// result fields from the updated state
	always_comb begin
		res.scl_level = nxt.scl;
		res.sda_drive = nxt.sda;
		res.sda_output_enable = nxt.oe;
		res.busy_res = (nxt.op != OP_IDLE);
		res.done_res = done;
		res.rx_byte = nxt.rx_last;
		res.ack_seen = nxt.ack;
	end

endmodule

// File: hdl/i2c_master_bit_sequencer_top.sv
// i2c master bit sequencer, top level: tick input register, sequencer state,
// result register and phase length register. Depends on i2cbs_pkg and i2cbs_step.
// A tick transfer is held in the input register, then its result loads into the result
// register once that register can take it. Throughput: one tick per cycle while the result
// side does not stall; the single-pass step logic between the two registers sets it. arst_n
// clears the sequencer to idle with SCL and SDA high and driven, phase length one tick.

module i2c_master_bit_sequencer_top import i2cbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic tick_valid,
	output logic tick_stall,
	input tick_t tick,
	output logic res_valid,
	input logic res_stall,
	output res_t res,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [PhaseW-1:0] cfg_data
);

	logic tick_valid_s1;
	tick_t tick_s1;
	seq_t seq_q;
	seq_t seq_nxt;
	res_t res_nxt;
	res_t res_s2;
	logic res_valid_s2;
	logic [PhaseW-1:0] phase_ticks_q;
	logic advance;

	// handshake: the input stage moves on whenever the result register can take it
	assign advance = tick_valid_s1 && (!res_valid_s2 || !res_stall);
	assign tick_stall = tick_valid_s1 && !advance;
	assign res_valid = res_valid_s2;
	assign res = res_s2;
	assign cfg_ready = 1'b1;

	// phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PhaseW'(1);
		end else if (cfg_valid && cfg_ready) begin
			phase_ticks_q <= cfg_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (tick_valid && !tick_stall) begin
			tick_valid_s1 <= 1'b1;
		end else if (advance) begin
			tick_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick;
		end
	end

	i2cbs_step u_step (
		.cur(seq_q),
		.tick(tick_s1),
		.phase_ticks(phase_ticks_q),
		.nxt(seq_nxt),
		.res(res_nxt)
	);

	// sequencer state, updated once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q.op <= OP_IDLE;
			seq_q.phase_step <= '0;
			seq_q.bit_index <= '0;
			seq_q.tick_counter <= '0;
			seq_q.shift_data <= '0;
			seq_q.rx_last <= '0;
			seq_q.ack <= 1'b1;
			seq_q.scl <= 1'b1;
			seq_q.sda <= 1'b1;
			seq_q.oe <= 1'b1;
		end else if (advance) begin
			seq_q <= seq_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

endmodule

// File: hdl/i2cbs_chk.sv
// i2cbs_chk: port-level checks for the i2c master bit sequencer, bound to the top level.
// Depends on i2cbs_pkg and i2c_master_bit_sequencer_top.

module i2cbs_chk import i2cbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic tick_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	// a stalled result holds until its transfer
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// the input side only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> res_valid && res_stall)
		else $error("input stalled with result side free");

	// the done tick is never a busy tick
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.done_res && res.busy_res))
		else $error("done and busy together");

	// a released sda line is always left at its high level
	a_release_high: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.sda_output_enable |-> res.sda_drive)
		else $error("sda released with drive value low");

endmodule

bind i2c_master_bit_sequencer_top i2cbs_chk u_chk (.*);

// File: sim/i2c_master_bit_sequencer_top_tb.sv
// Testbench for i2c_master_bit_sequencer_top: drives timing ticks and commands,
// predicts the pin and status result of every tick and checks each one in order.
// Depends on i2cbs_pkg and the block's RTL; needs no files or arguments.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_top_tb import i2cbs_pkg::*;;

	localparam int ProgDepth = 20;

	typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM} sda_mode_t;
	typedef enum int {NOISE_OFF, NOISE_SOME, NOISE_ALL} noise_t;

	logic clk;
	logic arst_n;
	logic tick_valid;
	logic tick_stall;
	tick_t tick;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [PhaseW-1:0] cfg_data;

	// sequencer mirror state
	op_t seq_op = OP_IDLE;
	int seq_pc = 0;
	int seq_bit = 0;
	int seq_count = 0;
	logic [7:0] seq_shift = 8'h00;
	logic [7:0] seq_rx = 8'h00;
	logic seq_ack = 1'b1;
	logic pin_scl = 1'b1;
	logic pin_sda = 1'b1;
	logic pin_oe = 1'b1;
	logic [15:0] phase_len = 16'd1;

	// phase programs per operation
	kind_t prog_kind [7][ProgDepth];
	int prog_arg [7][ProgDepth];
	int prog_len [7];

	res_t expected_pins [$];
	int mismatches = 0;
	int ticks_sent = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int stall_hold = 0;

	i2c_master_bit_sequencer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick(tick),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void put(op_t op, kind_t k, int a);
		prog_kind[op][prog_len[op]] = k;
		prog_arg[op][prog_len[op]] = a;
		prog_len[op]++;
	endfunction

	function automatic void build_programs();
		for (int o = 0; o < 7; o++) begin
			prog_len[o] = 0;
			for (int s = 0; s < ProgDepth; s++) begin
				prog_kind[o][s] = K_END;
				prog_arg[o][s] = 0;
			end
		end
		put(OP_START, K_OUT, 0); put(OP_START, K_SDA, 1); put(OP_START, K_SCL, 1);
		put(OP_START, K_SDA, 0); put(OP_START, K_SCL, 0);
		put(OP_STOP, K_OUT, 0); put(OP_STOP, K_SDA, 0); put(OP_STOP, K_SCL, 1);
		put(OP_STOP, K_SDA, 1);
		put(OP_WRITE, K_OUT, 0); put(OP_WRITE, K_SDA_BIT, 0); put(OP_WRITE, K_SCL, 1);
		put(OP_WRITE, K_SCL, 0); put(OP_WRITE, K_LOOP, 1); put(OP_WRITE, K_IN, 0);
		put(OP_WRITE, K_SCL, 1); put(OP_WRITE, K_RD_ACK, 0); put(OP_WRITE, K_SCL, 0);
		put(OP_WRITE, K_OUT, 0);
		put(OP_READ, K_OUT, 0); put(OP_READ, K_SDA, 1); put(OP_READ, K_IN, 0);
		put(OP_READ, K_SCL, 1); put(OP_READ, K_RD_BIT, 0); put(OP_READ, K_SCL, 0);
		put(OP_READ, K_LOOP, 2);
		put(OP_SEND_ACK, K_OUT, 0); put(OP_SEND_ACK, K_SDA_BIT, 0);
		put(OP_SEND_ACK, K_SCL, 1); put(OP_SEND_ACK, K_SCL, 0);
		put(OP_RECV_ACK, K_OUT, 0); put(OP_RECV_ACK, K_SDA, 1); put(OP_RECV_ACK, K_SCL, 1);
		put(OP_RECV_ACK, K_IN, 0); put(OP_RECV_ACK, K_RD_ACK, 0);
		put(OP_RECV_ACK, K_SCL, 0); put(OP_RECV_ACK, K_OUT, 0);
		// probe: start condition, address byte with ack, stop condition
		put(OP_PROBE, K_OUT, 0); put(OP_PROBE, K_SDA, 1); put(OP_PROBE, K_SCL, 1);
		put(OP_PROBE, K_SDA, 0); put(OP_PROBE, K_SCL, 0); put(OP_PROBE, K_OUT, 0);
		put(OP_PROBE, K_SDA_BIT, 0); put(OP_PROBE, K_SCL, 1); put(OP_PROBE, K_SCL, 0);
		put(OP_PROBE, K_LOOP, 6); put(OP_PROBE, K_IN, 0); put(OP_PROBE, K_SCL, 1);
		put(OP_PROBE, K_RD_ACK, 0); put(OP_PROBE, K_SCL, 0); put(OP_PROBE, K_OUT, 0);
		put(OP_PROBE, K_OUT, 0); put(OP_PROBE, K_SDA, 0); put(OP_PROBE, K_SCL, 1);
		put(OP_PROBE, K_SDA, 1);
	endfunction

	// run zero-time entries up to the next held phase; 0 at end of program
	function automatic bit advance_phase(logic sda_in);
		kind_t k;
		int a;
		for (int g = 0; g < 2 * ProgDepth; g++) begin
			if (seq_op == OP_IDLE || seq_pc >= ProgDepth)
				return 1'b0;
			k = prog_kind[seq_op][seq_pc];
			a = prog_arg[seq_op][seq_pc];
			seq_pc++;
			case (k)
				K_OUT: pin_oe = 1'b1;
				K_IN: begin
					pin_sda = 1'b1;
					pin_oe = 1'b0;
				end
				K_LOOP: begin
					if (seq_bit < 7) begin
						seq_bit++;
						seq_pc = a;
					end else begin
						seq_bit = 0;
					end
				end
				K_SDA: begin
					pin_sda = a[0];
					seq_count = 1;
					return 1'b1;
				end
				K_SDA_BIT: begin
					pin_sda = seq_shift[7 - seq_bit];
					seq_count = 1;
					return 1'b1;
				end
				K_SCL: begin
					pin_scl = a[0];
					seq_count = 1;
					return 1'b1;
				end
				K_RD_ACK: begin
					seq_ack = sda_in;
					seq_count = 1;
					return 1'b1;
				end
				K_RD_BIT: begin
					if (sda_in)
						seq_shift[7 - seq_bit] = 1'b1;
					seq_count = 1;
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		end
		return 1'b0;
	endfunction

	function automatic void close_sequence();
		if (seq_op == OP_READ)
			seq_rx = seq_shift;
		seq_op = OP_IDLE;
		seq_pc = 0;
		seq_bit = 0;
		seq_count = 0;
	endfunction

	// advance the mirror by one tick and return the pins and status after it
	function automatic res_t predict_pins(tick_t t);
		int lim;
		logic done;
		res_t r;
		lim = (phase_len == 16'd0) ? 1 : int'(phase_len);
		done = 1'b0;
		if (seq_op == OP_IDLE) begin
			if (t.cmd_valid && t.operation != OP_IDLE) begin
				seq_op = op_t'(t.operation);
				seq_pc = 0;
				seq_bit = 0;
				if (seq_op == OP_WRITE || seq_op == OP_PROBE)
					seq_shift = t.tx_byte;
				else if (seq_op == OP_SEND_ACK)
					seq_shift = {t.ack_to_send, 7'b0};
				else
					seq_shift = 8'h00;
				if (!advance_phase(t.sda_level)) begin
					close_sequence();
					done = 1'b1;
				end
			end
		end else if (seq_count < lim) begin
			seq_count++;
		end else if (!advance_phase(t.sda_level)) begin
			close_sequence();
			done = 1'b1;
		end
		r.scl_level = pin_scl;
		r.sda_drive = pin_sda;
		r.sda_output_enable = pin_oe;
		r.busy_res = (seq_op != OP_IDLE);
		r.done_res = done;
		r.rx_byte = seq_rx;
		r.ack_seen = seq_ack;
		return r;
	endfunction

	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endfunction

	task automatic check_result(res_t got);
		res_t want;
		if (expected_pins.size() == 0) begin
			mismatches++;
			$display("%0t: result with nothing expected, expected none got %h", $time, got);
			return;
		end
		want = expected_pins.pop_front();
		compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
		compare_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
		compare_field("sda_output_enable", 8'(want.sda_output_enable),
			8'(got.sda_output_enable));
		compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
		compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
		compare_field("rx_byte", want.rx_byte, got.rx_byte);
		compare_field("ack_seen", 8'(want.ack_seen), 8'(got.ack_seen));
	endtask

	// result side: random stall, long hold-offs on request, check every transfer
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall)
				check_result(res);
			if (stall_hold > 0) begin
				res_stall <= 1'b1;
				stall_hold--;
			end else begin
				res_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
			end
		end
	end

	function automatic tick_t random_tick(sda_mode_t mode);
		tick_t t;
		t.cmd_valid = 1'($urandom_range(1));
		t.operation = 3'($urandom_range(7));
		t.tx_byte = 8'($urandom_range(255));
		t.ack_to_send = 1'($urandom_range(1));
		case (mode)
			SDA_LOW: t.sda_level = 1'b0;
			SDA_HIGH: t.sda_level = 1'b1;
			default: t.sda_level = 1'($urandom_range(1));
		endcase
		return t;
	endfunction

	// one tick transfer, then predict its result
	task automatic send_tick(tick_t t);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			tick_valid <= 1'b0;
			@(posedge clk);
		end
		tick <= t;
		tick_valid <= 1'b1;
		do @(posedge clk); while (tick_stall);
		expected_pins.push_back(predict_pins(t));
		ticks_sent++;
	endtask

	// issue a command and keep ticking until the sequence has finished
	task automatic run_op(op_t op, logic [7:0] tx, logic ack_bit, sda_mode_t mode,
			noise_t noise);
		tick_t t;
		t = random_tick(mode);
		t.cmd_valid = 1'b1;
		t.operation = op;
		t.tx_byte = tx;
		t.ack_to_send = ack_bit;
		send_tick(t);
		while (seq_op != OP_IDLE) begin
			t = random_tick(mode);
			case (noise)
				NOISE_OFF: t.cmd_valid = 1'b0;
				NOISE_ALL: t.cmd_valid = 1'b1;
				default: t.cmd_valid = ($urandom_range(3) == 0);
			endcase
			send_tick(t);
		end
	endtask

	task automatic drain_results();
		tick_valid <= 1'b0;
		while (expected_pins.size() != 0) @(posedge clk);
	endtask

	// phase length write, only with the block idle and nothing outstanding
	task automatic set_phase_len(logic [15:0] v);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		phase_len = v;
	endtask

	// pins after reset, idle ticks and the unused operation code
	task automatic test_reset_values();
		tick_t t;
		t = random_tick(SDA_RANDOM);
		t.cmd_valid = 1'b0;
		repeat (3) send_tick(t);
		t.cmd_valid = 1'b1;
		t.operation = OP_IDLE;
		send_tick(t);
	endtask

	// every operation with field extremes, at the reset phase length
	task automatic test_operations();
		run_op(OP_START, 8'h00, 1'b0, SDA_RANDOM, NOISE_OFF);
		run_op(OP_WRITE, 8'h00, 1'b0, SDA_LOW, NOISE_OFF);
		run_op(OP_WRITE, 8'hFF, 1'b1, SDA_HIGH, NOISE_OFF);
		run_op(OP_WRITE, 8'hA5, 1'b0, SDA_RANDOM, NOISE_OFF);
		run_op(OP_READ, 8'h00, 1'b0, SDA_HIGH, NOISE_OFF);
		run_op(OP_READ, 8'hFF, 1'b1, SDA_LOW, NOISE_OFF);
		run_op(OP_READ, 8'h5A, 1'b0, SDA_RANDOM, NOISE_OFF);
		run_op(OP_SEND_ACK, 8'h00, 1'b0, SDA_RANDOM, NOISE_OFF);
		run_op(OP_SEND_ACK, 8'hFF, 1'b1, SDA_RANDOM, NOISE_OFF);
		run_op(OP_RECV_ACK, 8'h00, 1'b0, SDA_LOW, NOISE_OFF);
		run_op(OP_RECV_ACK, 8'h00, 1'b0, SDA_HIGH, NOISE_OFF);
		run_op(OP_PROBE, 8'hFF, 1'b0, SDA_LOW, NOISE_OFF);
		run_op(OP_PROBE, 8'h00, 1'b1, SDA_HIGH, NOISE_OFF);
		run_op(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, NOISE_OFF);
	endtask

	// commands on every busy tick, the done tick included, must be ignored
	task automatic test_busy_commands();
		run_op(OP_WRITE, 8'h3C, 1'b0, SDA_RANDOM, NOISE_ALL);
		run_op(OP_READ, 8'hC3, 1'b1, SDA_RANDOM, NOISE_ALL);
		run_op(OP_RECV_ACK, 8'h81, 1'b0, SDA_RANDOM, NOISE_ALL);
	endtask

	// short phase lengths, zero counting as one
	task automatic test_phase_lengths();
		logic [15:0] lens [3];
		lens = '{16'd0, 16'd2, 16'd3};
		foreach (lens[i]) begin
			set_phase_len(lens[i]);
			run_op(OP_PROBE, 8'($urandom_range(255)), 1'b0, SDA_RANDOM, NOISE_SOME);
			run_op(OP_READ, 8'h00, 1'b0, SDA_RANDOM, NOISE_SOME);
			run_op(OP_SEND_ACK, 8'h00, 1'($urandom_range(1)), SDA_RANDOM, NOISE_SOME);
		end
		set_phase_len(16'd1);
	endtask

	// long phase length on the shortest sequence, no idling
	task automatic test_long_phase();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		set_phase_len(16'd50);
		run_op(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, NOISE_SOME);
		set_phase_len(16'd1);
	endtask

	// result side held off while ticks keep coming, then the sender waits
	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		stall_hold = 300;
		run_op(OP_PROBE, 8'($urandom_range(255)), 1'b0, SDA_RANDOM, NOISE_SOME);
		run_op(OP_WRITE, 8'($urandom_range(255)), 1'b0, SDA_RANDOM, NOISE_SOME);
		drain_results();
		run_op(OP_READ, 8'h00, 1'b0, SDA_RANDOM, NOISE_SOME);
	endtask

	// random command sequences with random line levels
	task automatic test_random_traffic(int send_pct, int recv_pct, int n_ticks);
		int stop_at;
		int pick;
		tick_t t;
		sda_mode_t mode;
		stop_at = ticks_sent + n_ticks;
		send_gap_pct = send_pct;
		recv_stall_pct = recv_pct;
		while (ticks_sent < stop_at) begin
			pick = $urandom_range(19);
			if (pick == 0) begin
				set_phase_len(16'($urandom_range(3, 1)));
			end else if (pick < 3) begin
				t = random_tick(SDA_RANDOM);
				t.cmd_valid = (pick == 2);
				t.operation = OP_IDLE;
				send_tick(t);
			end else begin
				mode = ($urandom_range(3) == 0) ? sda_mode_t'($urandom_range(1)) : SDA_RANDOM;
				run_op(op_t'($urandom_range(6)), 8'($urandom_range(255)),
					1'($urandom_range(1)), mode, NOISE_SOME);
			end
		end
	endtask

	// main sequence
	initial begin
		build_programs();
		arst_n <= 1'b0;
		tick_valid <= 1'b0;
		tick <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_operations();
		test_busy_commands();
		test_phase_lengths();
		test_backpressure();
		test_long_phase();
		test_random_traffic(36, 84, 150);
		test_random_traffic(84, 36, 150);
		test_random_traffic(0, 0, 150);

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
